[rtl/ccc_pkg.sv]
`timescale 1ns / 1ps

package ccc_pkg;

   // Item commands.
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Time and date limits.
   localparam int SECOND_MAX   = 59;
   localparam int MINUTE_MAX   = 59;
   localparam int HOUR_MAX     = 23;
   localparam int MONTH_MAX    = 12;
   localparam int YEAR_MAX     = 9999;
   localparam int MONTH_FIRST  = 1;
   localparam int DAY_FIRST    = 1;
   localparam int TICKS_RESET  = 10;

   // Month numbers and lengths.
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_MAY = 4'd5;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_JUL = 4'd7;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAYS_LONG      = 5'd31;
   localparam logic [4:0] DAYS_SHORT     = 5'd30;
   localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB_COMMON = 5'd28;
   localparam logic [4:0] DAYS_NONE      = 5'd0;

   // Reciprocal of 100 scaled by 2^19; exact floor for any 14-bit year.
   localparam int RECIP_100       = 5243;
   localparam int RECIP_100_SHIFT = 19;
   localparam int CENTURY         = 100;

   // Control handed to each counter cell.
   typedef struct packed {
      logic load;
      logic step;
   } cell_ctl_type;

   // One result word.
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day_of_month;
      logic [3:0]  month;
      logic [13:0] year;
      logic        leap_year;
      logic        second_pulse;
   } rsp_word_type;

   // Leap year test: divisible by 4, except centuries not divisible by 400.
   function automatic logic is_leap(input logic [13:0] year);
      logic [26:0] prod;
      logic [7:0]  quot;
      logic [13:0] rem;
      prod = 27'(year) * 27'(RECIP_100);
      quot = prod[RECIP_100_SHIFT +: 8];
      rem  = year - 14'(15'(quot) * 15'(CENTURY));
      return (year[1:0] == 2'd0) && ((rem != 14'd0) || (quot[1:0] == 2'd0));
   endfunction

   // Days in a month; zero for a month number that means nothing.
   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
         MONTH_AUG, MONTH_OCT, MONTH_DEC: len = DAYS_LONG;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB_COMMON;
         default: len = DAYS_NONE;
      endcase
      return len;
   endfunction

endpackage

[rtl/ccc_if.sv]
`timescale 1ns / 1ps

// Input channel: one command word per handshake.
interface ccc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [5:0]  set_second;
   logic [5:0]  set_minute;
   logic [4:0]  set_hr;
   logic [4:0]  set_day;
   logic [3:0]  set_mon;
   logic [13:0] set_yr;

   modport source (
      output valid, command, set_second, set_minute, set_hr, set_day,
             set_mon, set_yr,
      input  ready
   );
   modport sink (
      input  valid, command, set_second, set_minute, set_hr, set_day,
             set_mon, set_yr,
      output ready
   );
endinterface

// Result channel: one time and date word per handshake.
interface ccc_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  second;
   logic [5:0]  minute;
   logic [4:0]  hour;
   logic [4:0]  day_of_month;
   logic [3:0]  month;
   logic [13:0] year;
   logic        leap_year;
   logic        second_pulse;

   modport source (
      output valid, second, minute, hour, day_of_month, month, year,
             leap_year, second_pulse,
      input  ready
   );
   modport sink (
      input  valid, second, minute, hour, day_of_month, month, year,
             leap_year, second_pulse,
      output ready
   );
endinterface

[rtl/ccc_cell.sv]
`timescale 1ns / 1ps

// One digit of the clock: counts up to a limit, then wraps and passes a carry on.
module ccc_cell
   import ccc_pkg::*;
#(
   parameter int WIDTH      = 6,
   parameter bit WRAP_ABOVE = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [WIDTH-1:0]   load_value,
   input  logic [WIDTH-1:0]   limit,
   input  logic [WIDTH-1:0]   wrap_value,
   output logic [WIDTH-1:0]   value,
   output logic [WIDTH-1:0]   value_in,
   output logic               carry_out
);

   logic [WIDTH-1:0] value_ff;
   logic             at_limit;
   logic             below_limit;

   assign below_limit = value_ff < limit;
   // A value past the limit either wraps or holds and stops the carry.
   assign at_limit    = (value_ff == limit) || (WRAP_ABOVE && (value_ff > limit));
   assign carry_out   = ctl.step && at_limit;

   // Next value: a load wins over a step.
   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = load_value;
      end else if (ctl.step) begin
         if (below_limit) begin
            value_in = value_ff + WIDTH'(1);
         end else if (at_limit) begin
            value_in = wrap_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

[rtl/ccc_skid.sv]
`timescale 1ns / 1ps

// Output register with a skid stage, so that ready upstream comes from a register.
module ccc_skid
   import ccc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_word_type in_word,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   logic         out_valid_ff;
   logic         skid_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type skid_word_ff;
   logic         accept;
   logic         out_free;

   assign in_ready = !skid_valid_ff;
   assign accept   = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   // Control: the skid stage fills only when the output register is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload.
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : in_word;
      end else if (accept) begin
         skid_word_ff <= in_word;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

[rtl/calendar_clock_counter_unit.sv]
`timescale 1ns / 1ps

// Real-time clock and calendar. Each request word is either a tick, which advances
// the sub-second prescaler, or a load, which sets the whole time and date and clears
// the prescaler; every request word yields one response word carrying the time and
// date after it, the leap-year flag and a pulse that marks a completed second. The
// state sits in a row of counter cells (prescaler, seconds, minutes, hours, day,
// month, year), each passing its carry to the next within the same cycle, so one
// word is taken every clock cycle while the output buffer has room, and its
// response is registered in the output buffer. Request ready comes from a register
// and stays high while the response is being taken; a two-deep output buffer
// absorbs one word of back-pressure. csr_wr_data sets the number of ticks per
// second (reset value 10, zero acts as one) and should be written only while idle.
module calendar_clock_counter_unit
   import ccc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data,
   ccc_req_if.sink     req,
   ccc_rsp_if.source   rsp
);

   logic [9:0]   tps_ff;
   logic [9:0]   pre_limit;
   logic         accept;
   logic         load;
   logic         leap_ff;
   logic         leap_in;
   rsp_word_type rsp_word_in;
   rsp_word_type rsp_word;

   cell_ctl_type pre_ctl, sec_ctl, min_ctl, hour_ctl, day_ctl, mon_ctl, year_ctl;
   logic         pre_carry, sec_carry, min_carry, hour_carry, day_carry, mon_carry;
   logic         year_carry;
   logic [9:0]   pre_value, pre_in;
   logic [5:0]   sec_value, sec_in;
   logic [5:0]   min_value, min_in;
   logic [4:0]   hour_value, hour_in;
   logic [4:0]   day_value, day_in;
   logic [3:0]   mon_value, mon_in;
   logic [13:0]  year_value, year_in;
   logic [4:0]   day_limit;

   // Ticks-per-second register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= 10'(TICKS_RESET);
      end else if (csr_wr_en) begin
         tps_ff <= csr_wr_data;
      end
   end

   assign pre_limit = (tps_ff == 10'd0) ? 10'd0 : tps_ff - 10'd1;
   assign accept    = req.valid && req.ready;
   assign load      = accept && (req.command == CMD_LOAD);
   assign day_limit = month_length(mon_value, leap_ff);

   // Carry chain control: each cell steps on the carry of the one before.
   always_comb begin
      pre_ctl.load  = load;
      pre_ctl.step  = accept && (req.command == CMD_TICK);
      sec_ctl.load  = load;
      sec_ctl.step  = pre_carry;
      min_ctl.load  = load;
      min_ctl.step  = sec_carry;
      hour_ctl.load = load;
      hour_ctl.step = min_carry;
      day_ctl.load  = load;
      day_ctl.step  = hour_carry && (day_limit != DAYS_NONE);
      mon_ctl.load  = load;
      mon_ctl.step  = day_carry;
      year_ctl.load = load;
      year_ctl.step = mon_carry;
   end

   ccc_cell #(.WIDTH(10), .WRAP_ABOVE(1'b1)) u_pre (
      .clock(clock), .reset(reset), .ctl(pre_ctl), .load_value(10'd0),
      .limit(pre_limit), .wrap_value(10'd0),
      .value(pre_value), .value_in(pre_in), .carry_out(pre_carry)
   );

   ccc_cell #(.WIDTH(6), .WRAP_ABOVE(1'b0)) u_sec (
      .clock(clock), .reset(reset), .ctl(sec_ctl), .load_value(req.set_second),
      .limit(6'(SECOND_MAX)), .wrap_value(6'd0),
      .value(sec_value), .value_in(sec_in), .carry_out(sec_carry)
   );

   ccc_cell #(.WIDTH(6), .WRAP_ABOVE(1'b0)) u_min (
      .clock(clock), .reset(reset), .ctl(min_ctl), .load_value(req.set_minute),
      .limit(6'(MINUTE_MAX)), .wrap_value(6'd0),
      .value(min_value), .value_in(min_in), .carry_out(min_carry)
   );

   ccc_cell #(.WIDTH(5), .WRAP_ABOVE(1'b0)) u_hour (
      .clock(clock), .reset(reset), .ctl(hour_ctl), .load_value(req.set_hr),
      .limit(5'(HOUR_MAX)), .wrap_value(5'd0),
      .value(hour_value), .value_in(hour_in), .carry_out(hour_carry)
   );

   // A day past the month length holds; an unset month keeps the day cell still.
   ccc_cell #(.WIDTH(5), .WRAP_ABOVE(1'b0)) u_day (
      .clock(clock), .reset(reset), .ctl(day_ctl), .load_value(req.set_day),
      .limit(day_limit), .wrap_value(5'(DAY_FIRST)),
      .value(day_value), .value_in(day_in), .carry_out(day_carry)
   );

   ccc_cell #(.WIDTH(4), .WRAP_ABOVE(1'b0)) u_mon (
      .clock(clock), .reset(reset), .ctl(mon_ctl), .load_value(req.set_mon),
      .limit(4'(MONTH_MAX)), .wrap_value(4'(MONTH_FIRST)),
      .value(mon_value), .value_in(mon_in), .carry_out(mon_carry)
   );

   // The year wraps to zero from the last year or anything above it.
   ccc_cell #(.WIDTH(14), .WRAP_ABOVE(1'b1)) u_year (
      .clock(clock), .reset(reset), .ctl(year_ctl), .load_value(req.set_yr),
      .limit(14'(YEAR_MAX)), .wrap_value(14'd0),
      .value(year_value), .value_in(year_in), .carry_out(year_carry)
   );

   // Leap flag of the stored year, kept alongside it; year zero is a leap year.
   assign leap_in = is_leap(year_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_ff <= 1'b1;
      end else if (accept) begin
         leap_ff <= leap_in;
      end
   end

   // Response word from the state after this item.
   always_comb begin
      rsp_word_in.second       = sec_in;
      rsp_word_in.minute       = min_in;
      rsp_word_in.hour         = hour_in;
      rsp_word_in.day_of_month = day_in;
      rsp_word_in.month        = mon_in;
      rsp_word_in.year         = year_in;
      rsp_word_in.leap_year    = leap_in;
      rsp_word_in.second_pulse = pre_carry;
   end

   ccc_skid u_skid (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_word(rsp_word_in),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp_word)
   );

   assign rsp.second       = rsp_word.second;
   assign rsp.minute       = rsp_word.minute;
   assign rsp.hour         = rsp_word.hour;
   assign rsp.day_of_month = rsp_word.day_of_month;
   assign rsp.month        = rsp_word.month;
   assign rsp.year         = rsp_word.year;
   assign rsp.leap_year    = rsp_word.leap_year;
   assign rsp.second_pulse = rsp_word.second_pulse;

   // A load always leaves the prescaler cleared.
   a_load_clears_prescaler: assert property (@(posedge clock) disable iff (reset)
      load |=> (pre_value == 10'd0))
      else $error("prescaler not cleared by load");

   // A tick that does not complete a second steps the prescaler by one and leaves
   // the seconds alone.
   a_seconds_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.command == CMD_TICK) && !pre_carry)
         |-> ((sec_in == sec_value) && (pre_in == pre_value + 10'd1)))
      else $error("seconds moved without a completed second");

   // The year only moves on a load or on the carry out of December.
   a_year_moves_on_carry: assert property (@(posedge clock) disable iff (reset)
      (!load && !year_ctl.step) |=> $stable(year_value))
      else $error("year changed without a load or carry");

   // A carry out of December wraps the month to January, and a carry out of the
   // last year takes the year back to zero.
   a_month_wrap: assert property (@(posedge clock) disable iff (reset)
      (mon_carry && !load) |=> ((mon_value == 4'(MONTH_FIRST)) &&
                                (!$past(year_carry) || (year_value == 14'd0))))
      else $error("month did not wrap with the year carry");

   // Between accepted words the stored time and date stand still.
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable({pre_value, sec_value, min_value, hour_value, day_value,
                           mon_value, year_value}))
      else $error("time moved without an accepted word");

endmodule
